// File: src/pidat_pkg.sv
// shared types and constants for the pid altitude throttle block
// no dependencies
package pidat_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 8;
  localparam int DATA_W    = 32;
  localparam int ERR_W     = 33;
  localparam int DIFF_W    = 34;
  localparam int QUO_W     = 34;
  localparam int INTEG_W   = 48;
  localparam int MULX_W    = 48;
  localparam int PROD_W    = 64;
  localparam int SUM_W     = 58;
  localparam int ADDR_W    = 5;

  localparam logic [DATA_W-1:0] TARGET_RESET = DATA_W'(2) << FRAC_BITS;
  localparam logic [GAIN_W-1:0] KP_RESET     = GAIN_W'(256);
  localparam logic [GAIN_W-1:0] KI_RESET     = GAIN_W'(0);
  localparam logic [GAIN_W-1:0] KD_RESET     = GAIN_W'(128);
  localparam logic [DATA_W-1:0] HOVER_RESET  = DATA_W'(0);

  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_KP     = 3'd1,
    REG_KI     = 3'd2,
    REG_KD     = 3'd3,
    REG_HOVER  = 3'd4
  } reg_idx_t;

  typedef logic [GAIN_W-1:0]        gain_t;
  typedef logic signed [MULX_W-1:0] mul_x_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] target_height;
    gain_t                    gain_proportional;
    gain_t                    gain_integral;
    gain_t                    gain_derivative;
    logic signed [DATA_W-1:0] hover_throttle;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] measured_height;
    logic [GAIN_W-1:0]        step_ms;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] throttle;
    logic                     saturated;
  } out_t;

endpackage

// File: src/pidat_regs.sv
// apb-style configuration registers for the pid altitude throttle block
// depends on pidat_pkg
module pidat_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidat_pkg::ADDR_W-1:0]  paddr,
  input  logic [pidat_pkg::DATA_W-1:0]  pwdata,
  output logic [pidat_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output pidat_pkg::cfg_t               cfg
);
  import pidat_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_TARGET: cfg_nxt.target_height     = pwdata;
        REG_KP:     cfg_nxt.gain_proportional = pwdata[GAIN_W-1:0];
        REG_KI:     cfg_nxt.gain_integral     = pwdata[GAIN_W-1:0];
        REG_KD:     cfg_nxt.gain_derivative   = pwdata[GAIN_W-1:0];
        REG_HOVER:  cfg_nxt.hover_throttle    = pwdata;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TARGET: prdata = cfg_r.target_height;
      REG_KP:     prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_r.gain_proportional};
      REG_KI:     prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_r.gain_integral};
      REG_KD:     prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_r.gain_derivative};
      REG_HOVER:  prdata = cfg_r.hover_throttle;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_height     <= TARGET_RESET;
      cfg_r.gain_proportional <= KP_RESET;
      cfg_r.gain_integral     <= KI_RESET;
      cfg_r.gain_derivative   <= KD_RESET;
      cfg_r.hover_throttle    <= HOVER_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: src/pidat_mul.sv
// bit-serial multiplier: signed multiplicand times unsigned 16-bit gain, one gain bit per cycle
// depends on pidat_pkg
module pidat_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  pidat_pkg::mul_x_t x,
  input  pidat_pkg::gain_t  m,
  output logic              busy,
  output pidat_pkg::prod_t  prod
);
  import pidat_pkg::*;

  localparam int CNT_W = $clog2(GAIN_W);

  mul_x_t           x_r;
  gain_t            m_r;
  prod_t            acc_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  prod_t            addend;

  assign addend = m_r[GAIN_W-1] ? {{(PROD_W-MULX_W){x_r[MULX_W-1]}}, x_r} : '0;
  assign busy   = busy_r;
  assign prod   = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(GAIN_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      m_r   <= m;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= (acc_r <<< 1) + addend;
      m_r   <= m_r << 1;
    end
  end

endmodule

// File: src/pidat_div.sv
// bit-serial restoring divider: 34-bit magnitude by 16-bit divisor, one quotient bit per cycle
// depends on pidat_pkg
module pidat_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pidat_pkg::QUO_W-1:0]  dividend,
  input  pidat_pkg::gain_t             divisor,
  output logic                         busy,
  output logic [pidat_pkg::QUO_W-1:0]  quotient
);
  import pidat_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic [QUO_W-1:0]  q_r;
  logic [GAIN_W-1:0] rem_r;
  gain_t             d_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic [GAIN_W:0]   trial;
  logic [GAIN_W:0]   trial_sub;
  logic              ge;

  assign trial     = {rem_r, q_r[QUO_W-1]};
  assign trial_sub = trial - {1'b0, d_r};
  assign ge        = trial >= {1'b0, d_r};
  assign busy      = busy_r;
  assign quotient  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(QUO_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[QUO_W-2:0], ge};
      rem_r <= ge ? trial_sub[GAIN_W-1:0] : trial[GAIN_W-1:0];
    end
  end

endmodule

// File: src/pid_altitude_throttle_top.sv
// pid altitude throttle controller with feedforward, top level and sequencer
// depends on pidat_pkg, pidat_regs, pidat_mul, pidat_div
//
// usage:
//   input channel (in_valid/in_ready/in_data) takes one transaction per control
//   step: measured height (signed q16.16) and elapsed time in ms.
//   output channel (out_valid/out_ready/out_data) returns one transaction per
//   input: the saturated throttle and a flag set when the throttle or the
//   integral clipped.
//   the apb-style port sets target height, three q8.8 gains and hover throttle;
//   registers sit at byte addresses 0, 4, 8, 12, 16.
// sequencing:
//   one item is in work at a time, so a new input is taken only when the
//   sequencer is back in idle. the shared bit-serial multiplier runs four
//   products in turn; the bit-serial divider for the derivative runs
//   alongside it.
// reset:
//   registers return to their defaults, integral and previous error clear.
// stall:
//   a finished result waits in the output register; the next item is accepted
//   and worked on, and holds its result until the output register is free.
module pid_altitude_throttle_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pidat_pkg::in_t                in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pidat_pkg::out_t               out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidat_pkg::ADDR_W-1:0]  paddr,
  input  logic [pidat_pkg::DATA_W-1:0]  pwdata,
  output logic [pidat_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import pidat_pkg::*;

  localparam int IS_W = INTEG_W + 2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_M_DT  = 7'b0000100,
    S_M_P   = 7'b0001000,
    S_M_I   = 7'b0010000,
    S_M_D   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  cfg_t   cfg;
  state_t state_r, state_nxt;

  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [ERR_W-1:0]   prev_r, prev_nxt;
  logic signed [DIFF_W-1:0]  diff_r, diff_nxt;
  gain_t                     dt_r, dt_nxt;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic                      clip_r, clip_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_t                      out_r, out_nxt;

  logic                      mul_start, mul_busy;
  mul_x_t                    mul_x;
  gain_t                     mul_m;
  prod_t                     mul_prod;
  logic                      div_start, div_busy;
  logic [QUO_W-1:0]          div_q;
  logic [DIFF_W-1:0]         diff_mag;
  logic signed [DIFF_W-1:0]  deriv;
  logic signed [IS_W-1:0]    integ_sum;
  logic signed [SUM_W-1:0]   prod_scaled;
  logic                      out_free;

  pidat_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pidat_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mul_x),
    .m     (mul_m),
    .busy  (mul_busy),
    .prod  (mul_prod)
  );

  pidat_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff_mag[QUO_W-1:0]),
    .divisor  (dt_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign diff_mag    = diff_r[DIFF_W-1] ? -diff_r : diff_r;
  assign deriv       = (dt_r == '0) ? '0
                     : (diff_r[DIFF_W-1] ? -div_q : div_q);
  assign integ_sum   = {{2{integ_r[INTEG_W-1]}}, integ_r} + mul_prod[IS_W-1:0];
  assign prod_scaled = {{(SUM_W-PROD_W+GAIN_FRAC){mul_prod[PROD_W-1]}},
                        mul_prod[PROD_W-1:GAIN_FRAC]};
  assign out_free    = !out_valid_r || out_ready;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    err_nxt       = err_r;
    prev_nxt      = prev_r;
    diff_nxt      = diff_r;
    dt_nxt        = dt_r;
    integ_nxt     = integ_r;
    sum_nxt       = sum_r;
    clip_nxt      = clip_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mul_start     = 1'b0;
    mul_x         = {{(MULX_W-ERR_W){err_r[ERR_W-1]}}, err_r};
    mul_m         = dt_r;
    div_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          err_nxt   = {cfg.target_height[DATA_W-1], cfg.target_height}
                    - {in_data.measured_height[DATA_W-1], in_data.measured_height};
          diff_nxt  = {err_nxt[ERR_W-1], err_nxt} - {prev_r[ERR_W-1], prev_r};
          prev_nxt  = err_nxt;
          dt_nxt    = in_data.step_ms;
          sum_nxt   = {{(SUM_W-DATA_W){cfg.hover_throttle[DATA_W-1]}}, cfg.hover_throttle};
          clip_nxt  = 1'b0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        mul_start = 1'b1;
        div_start = 1'b1;
        state_nxt = S_M_DT;
      end
      S_M_DT: begin
        if (!mul_busy) begin
          if (dt_r != '0) begin
            if (integ_sum[IS_W-1:INTEG_W-1] != '0 && integ_sum[IS_W-1:INTEG_W-1] != '1) begin
              clip_nxt  = 1'b1;
              integ_nxt = integ_sum[IS_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                            : {1'b0, {(INTEG_W-1){1'b1}}};
            end else begin
              integ_nxt = integ_sum[INTEG_W-1:0];
            end
          end
          mul_start = 1'b1;
          mul_m     = cfg.gain_proportional;
          state_nxt = S_M_P;
        end
      end
      S_M_P: begin
        if (!mul_busy) begin
          sum_nxt   = sum_r + prod_scaled;
          mul_start = 1'b1;
          mul_x     = integ_r;
          mul_m     = cfg.gain_integral;
          state_nxt = S_M_I;
        end
      end
      S_M_I: begin
        if (!mul_busy && !div_busy) begin
          sum_nxt   = sum_r + prod_scaled;
          mul_start = 1'b1;
          mul_x     = {{(MULX_W-DIFF_W){deriv[DIFF_W-1]}}, deriv};
          mul_m     = cfg.gain_derivative;
          state_nxt = S_M_D;
        end
      end
      S_M_D: begin
        if (!mul_busy) begin
          sum_nxt   = sum_r + prod_scaled;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          if (sum_r[SUM_W-1:DATA_W-1] != '0 && sum_r[SUM_W-1:DATA_W-1] != '1) begin
            out_nxt.throttle  = sum_r[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                               : {1'b0, {(DATA_W-1){1'b1}}};
            out_nxt.saturated = 1'b1;
          end else begin
            out_nxt.throttle  = sum_r[DATA_W-1:0];
            out_nxt.saturated = clip_r;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      prev_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r     <= integ_nxt;
      prev_r      <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r  <= err_nxt;
    diff_r <= diff_nxt;
    dt_r   <= dt_nxt;
    sum_r  <= sum_nxt;
    clip_r <= clip_nxt;
    out_r  <= out_nxt;
  end

endmodule

// File: bench/pidat_checker.sv
// checker for the pid altitude throttle block: tracks register writes, predicts
// each throttle transaction from the accepted inputs and compares the outputs
// depends on pidat_pkg
`timescale 1ns / 100ps

module pidat_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  pidat_pkg::in_t                in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  pidat_pkg::out_t               out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [pidat_pkg::ADDR_W-1:0]  paddr,
  input  logic [pidat_pkg::DATA_W-1:0]  pwdata,
  output int unsigned                   mismatches,
  output int unsigned                   pending
);
  import pidat_pkg::*;

  localparam longint INTEG_HI    = (longint'(1) <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_LO    = -INTEG_HI - 1;
  localparam longint THROTTLE_HI = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint THROTTLE_LO = -THROTTLE_HI - 1;

  cfg_t                      settings;
  logic signed [INTEG_W-1:0] integ;
  logic signed [ERR_W-1:0]   last_error;
  out_t                      throttle_q[$];

  function automatic out_t step_controller(input in_t item);
    longint err;
    longint span;
    longint acc;
    longint slope;
    longint total;
    logic   clipped;
    out_t   res;
    span = longint'(item.step_ms);
    err = longint'($signed(settings.target_height)) - longint'($signed(item.measured_height));
    slope = 0;
    clipped = 1'b0;
    if (span != 0) begin
      acc = longint'(integ) + err * span;
      if (acc > INTEG_HI) begin
        acc = INTEG_HI;
        clipped = 1'b1;
      end
      if (acc < INTEG_LO) begin
        acc = INTEG_LO;
        clipped = 1'b1;
      end
      integ = INTEG_W'(acc);
      slope = (err - longint'(last_error)) / span;
    end
    last_error = ERR_W'(err);
    total = ((longint'(settings.gain_proportional) * err) >>> GAIN_FRAC)
          + ((longint'(settings.gain_integral) * longint'(integ)) >>> GAIN_FRAC)
          + ((longint'(settings.gain_derivative) * slope) >>> GAIN_FRAC)
          + longint'($signed(settings.hover_throttle));
    if (total > THROTTLE_HI) begin
      total = THROTTLE_HI;
      clipped = 1'b1;
    end
    if (total < THROTTLE_LO) begin
      total = THROTTLE_LO;
      clipped = 1'b1;
    end
    res.throttle = DATA_W'(total);
    res.saturated = clipped;
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    out_t want;
    if (!rst_n) begin
      settings = '{TARGET_RESET, KP_RESET, KI_RESET, KD_RESET, HOVER_RESET};
      integ = '0;
      last_error = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_TARGET: settings.target_height = pwdata;
          REG_KP:     settings.gain_proportional = pwdata[GAIN_W-1:0];
          REG_KI:     settings.gain_integral = pwdata[GAIN_W-1:0];
          REG_KD:     settings.gain_derivative = pwdata[GAIN_W-1:0];
          REG_HOVER:  settings.hover_throttle = pwdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (throttle_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction throttle %0d saturated %0b",
                   $time, out_data.throttle, out_data.saturated);
        end else begin
          want = throttle_q.pop_front();
          if (out_data.throttle !== want.throttle) begin
            mismatches++;
            $display("%0t: throttle expected %0d actual %0d",
                     $time, want.throttle, out_data.throttle);
          end
          if (out_data.saturated !== want.saturated) begin
            mismatches++;
            $display("%0t: saturated expected %0b actual %0b",
                     $time, want.saturated, out_data.saturated);
          end
        end
      end
      if (in_valid && in_ready) throttle_q.push_back(step_controller(in_data));
    end
    pending = throttle_q.size();
  end

endmodule

// File: bench/testbench.sv
// top of the pid altitude throttle bench: clock, reset, register setup and
// height/time-step stimulus with random idling; verdict from pidat_checker
// depends on pidat_pkg, pidat_checker, pid_altitude_throttle_top
`timescale 1ns / 100ps

module testbench;
  import pidat_pkg::*;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 180;
  localparam int HOLD_PHASE   = 3;
  localparam int QUIET_PHASE  = 5;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [2:0] SPARE_IDX = 3'(REG_HOVER) + 3'd1;
  localparam logic [DATA_W-1:0] MAX_LEVEL = 32'h7fffffff;
  localparam logic [DATA_W-1:0] MIN_LEVEL = 32'h80000000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_data;
  logic                out_valid;
  logic                out_ready;
  out_t                out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  int unsigned         mismatches;
  int unsigned         pending;
  logic                calm;
  int unsigned         hold_requests;
  int unsigned         holds_done;
  logic [DATA_W-1:0]   cur_target;

  always #5 clk = ~clk;

  pid_altitude_throttle_top i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pidat_checker i_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .mismatches, .pending
  );

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    if (idx == REG_TARGET) cur_target = value;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [DATA_W-1:0] target, input gain_t kp,
                               input gain_t ki, input gain_t kd,
                               input logic [DATA_W-1:0] hover);
    write_reg(REG_TARGET, target);
    write_reg(REG_KP, DATA_W'(kp));
    write_reg(REG_KI, DATA_W'(ki));
    write_reg(REG_KD, DATA_W'(kd));
    write_reg(REG_HOVER, hover);
  endtask

  task automatic send_item(input logic [DATA_W-1:0] height, input logic [GAIN_W-1:0] step);
    in_data <= '{measured_height: height, step_ms: step};
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_level;
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = MAX_LEVEL;
      1: v = MIN_LEVEL;
      2: v = '0;
      3: v = $urandom;
      default: v = DATA_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
    return v;
  endfunction

  function automatic gain_t pick_gain;
    gain_t g;
    case ($urandom_range(0, 5))
      0: g = '0;
      1: g = '1;
      2: g = gain_t'($urandom);
      default: g = gain_t'($urandom_range(0, 1024));
    endcase
    return g;
  endfunction

  function automatic logic [DATA_W-1:0] pick_height;
    logic [DATA_W-1:0] h;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: h = cur_target + DATA_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      4, 5, 6: h = cur_target + DATA_W'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
      7, 8: h = $urandom;
      default: h = $urandom_range(0, 1) ? MAX_LEVEL : MIN_LEVEL;
    endcase
    return h;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_step;
    logic [GAIN_W-1:0] s;
    case ($urandom_range(0, 19))
      0, 1: s = '0;
      2, 3, 4, 5, 6, 7, 8, 9, 10: s = GAIN_W'($urandom_range(1, 20));
      11, 12, 13, 14, 15: s = GAIN_W'($urandom_range(21, 1000));
      16, 17, 18: s = GAIN_W'($urandom);
      default: s = '1;
    endcase
    return s;
  endfunction

  // result side: random backpressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 26);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    hold_requests = 0;
    cur_target = TARGET_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero error, zero steps, integral clipping both ways
    send_item(TARGET_RESET, 16'd1);
    send_item('0, '0);
    send_item('0, 16'd1);
    send_item(MIN_LEVEL, '1);
    send_item(MIN_LEVEL, '1);
    send_item(MAX_LEVEL, '1);
    send_item(MAX_LEVEL, '1);
    send_item(MAX_LEVEL, '1);
    send_item(MAX_LEVEL, '1);
    send_item(32'h00030000, 16'd3);
    send_item(32'h00010000, 16'd7);
    send_item(32'hfffe0001, 16'd5);
    send_item(TARGET_RESET, '0);
    drain();
    // write past the last register must change nothing
    write_reg(SPARE_IDX, $urandom);
    send_item('0, 16'd1);
    send_item(32'h12345678, 16'd2);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: load_settings(MAX_LEVEL, '1, '1, '1, MAX_LEVEL);
        1: load_settings(MIN_LEVEL, '0, '0, '0, MIN_LEVEL);
        2: load_settings(MIN_LEVEL, '1, '0, '1, '0);
        default: load_settings(pick_level(), pick_gain(), pick_gain(), pick_gain(),
                               pick_level());
      endcase
      calm <= (p == QUIET_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == HOLD_PHASE && n == 40) hold_requests <= hold_requests + 1;
        if (p == HOLD_PHASE && n == 90) drain();
        if (p != QUIET_PHASE && $urandom_range(0, 99) < 26) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 90)) @(posedge clk);
        end
        send_item(pick_height(), pick_step());
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
